>>> hdl/pwlti_pkg.sv
// package for the piecewise-linear interpolation table
// shared constants, codes and types; no dependencies
package pwlti_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int DATA_W          = 32;
    localparam int IDX_W           = 6;
    localparam int CNT_W           = 7;
    localparam int MODE_W          = 2;
    localparam int STAT_W          = 2;

    // configuration register indexes
    localparam logic [0:0] REG_BOUNDS  = 1'b0;
    localparam logic [0:0] REG_ENTRIES = 1'b1;

    // bounds modes
    localparam logic [MODE_W-1:0] MODE_ERROR  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WARN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLAMP  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_WARN  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ERROR = 2'd2;
    localparam logic [STAT_W-1:0] ST_ORDER = 2'd3;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // word handed from front to back
    typedef struct packed {
        logic                     action;
        logic [IDX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0] entry_y;
        logic signed [DATA_W-1:0] key_x;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ0,
        S_READN,
        S_CLASS,
        S_MODDIV,
        S_SCAN,
        S_SCANW,
        S_FETCH,
        S_FETCHW,
        S_DIV1,
        S_DIV2,
        S_DIV3,
        S_DONE,
        S_LOAD,
        S_LOADW
    } state_t;

endpackage

>>> hdl/pwlti_if.sv
// valid/ready channel interface
// depends on nothing; payload type is a parameter
interface pwlti_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/pwlti_in_t.sv
// input word and result word types for the channels
// depends on pwlti_pkg
package pwlti_io_pkg;
    typedef struct packed {
        logic                                       action;
        logic [pwlti_pkg::IDX_W-1:0]                entry_index;
        logic signed [pwlti_pkg::DATA_W-1:0]        entry_y;
        logic signed [pwlti_pkg::DATA_W-1:0]        key_x;
    } in_word_t;
    typedef struct packed {
        logic signed [pwlti_pkg::DATA_W-1:0]        interp_value;
        logic signed [pwlti_pkg::DATA_W-1:0]        slope;
        logic [pwlti_pkg::STAT_W-1:0]               status;
    } out_word_t;
endpackage

>>> hdl/pwlti_fifo.sv
// two-entry queue between front and back
// depends on pwlti_pkg
module pwlti_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pwlti_pkg::cmd_t   push_data,
    output logic              full,
    input  logic              pop,
    output pwlti_pkg::cmd_t   pop_data,
    output logic              empty
);
    pwlti_pkg::cmd_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem_reg[rp_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop && !empty)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, (push && !full)} - {1'b0, (pop && !empty)};
        end
    end
endmodule

>>> hdl/pwlti_div.sv
// restoring divider, one quotient bit a cycle, unsigned
// depends on nothing
module pwlti_div #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 34
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);
    localparam int CW = $clog2(NUM_W + 1);
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   r_reg;
    logic [DEN_W-1:0] d_reg;
    logic [CW-1:0]    n_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   shifted;

    assign busy    = (n_reg != '0);
    assign quot    = q_reg;
    assign rem     = r_reg[DEN_W-1:0];
    assign shifted = {r_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign trial   = shifted - {1'b0, d_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= '0;
        end
        else if (start)
        begin
            n_reg <= CW'(NUM_W);
        end
        else if (busy)
        begin
            n_reg <= n_reg - 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy)
        begin
            if (!trial[DEN_W])
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted;
                q_reg <= {q_reg[NUM_W-2:0], 1'b0};
            end
        end
    end
endmodule

>>> hdl/pwlti_back.sv
// back end: table memory, segment scan, division and result register
// depends on pwlti_pkg, pwlti_io_pkg, pwlti_div
module pwlti_back #(
    parameter int TABLE_DEPTH = pwlti_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = pwlti_pkg::FRAC_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    input  pwlti_pkg::cmd_t                 cmd,
    output logic                            cmd_pop,
    input  logic [pwlti_pkg::MODE_W-1:0]    mode,
    input  logic [pwlti_pkg::CNT_W-1:0]     entries,
    output logic                            res_valid,
    input  logic                            res_ready,
    output pwlti_io_pkg::out_word_t         res
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int W  = pwlti_pkg::DATA_W;
    localparam int NUM_W = 2 * (W + 2);
    localparam int DEN_W = W + 2;

    pwlti_pkg::state_t state_reg, state_next;

    logic signed [W-1:0] xmem [TABLE_DEPTH];
    logic signed [W-1:0] ymem [TABLE_DEPTH];
    logic signed [W-1:0] xrd_reg, yrd_reg;
    logic [AW-1:0]       raddr;

    pwlti_pkg::cmd_t     c_reg;
    logic [NW-1:0]       n_reg;
    logic [AW-1:0]       i_reg;
    logic signed [W-1:0] x0_reg, y0_reg, xn_reg, yn_reg;
    logic signed [W+1:0] q_reg;
    logic signed [W-1:0] xlo_reg, ylo_reg, xhi_reg, yhi_reg;
    logic                neg_reg;
    logic [DEN_W-1:0]    ady_reg, dx_reg, t_reg;
    logic [DEN_W+FRAC_BITS-1:0] sm_reg;
    logic [NUM_W-1:0]    hiq_reg;
    pwlti_io_pkg::out_word_t res_reg;
    logic                rv_reg;

    logic                dstart, dbusy;
    logic [NUM_W-1:0]    dnum, dquot;
    logic [DEN_W-1:0]    dden, drem;

    logic [NW-1:0]       nclip;
    logic signed [W+1:0] span, rel;

    logic go_mod, go_scan, scan_end, scan_flat, below, above;
    logic [AW-1:0] last;
    logic [DEN_W-1:0] ady_now;

    assign nclip = (entries == '0) ? NW'(1)
                 : ({{(32-pwlti_pkg::CNT_W){1'b0}}, entries} > 32'(TABLE_DEPTH))
                   ? NW'(TABLE_DEPTH) : NW'(entries);
    assign span  = (W+2)'(xn_reg) - (W+2)'(x0_reg);
    assign rel   = (W+2)'(c_reg.key_x) - (W+2)'(x0_reg);

    pwlti_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(dden),
        .busy(dbusy), .quot(dquot), .rem(drem)
    );

    assign res_valid = rv_reg;
    assign res       = res_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pwlti_pkg::S_IDLE:
                if (cmd_valid && !rv_reg)
                    state_next = (cmd.action == pwlti_pkg::ACT_LOAD)
                               ? pwlti_pkg::S_LOAD : pwlti_pkg::S_READ0;
            pwlti_pkg::S_LOAD:   state_next = pwlti_pkg::S_LOADW;
            pwlti_pkg::S_LOADW:  state_next = pwlti_pkg::S_DONE;
            pwlti_pkg::S_READ0:  state_next = pwlti_pkg::S_READN;
            pwlti_pkg::S_READN:  state_next = pwlti_pkg::S_CLASS;
            pwlti_pkg::S_CLASS:  state_next = pwlti_pkg::S_DONE;
            pwlti_pkg::S_MODDIV: if (!dbusy) state_next = pwlti_pkg::S_SCAN;
            pwlti_pkg::S_SCAN:   state_next = pwlti_pkg::S_SCANW;
            pwlti_pkg::S_SCANW:  state_next = pwlti_pkg::S_SCAN;
            pwlti_pkg::S_FETCH:  state_next = pwlti_pkg::S_FETCHW;
            pwlti_pkg::S_FETCHW: state_next = pwlti_pkg::S_DIV1;
            pwlti_pkg::S_DIV1:   if (!dbusy) state_next = pwlti_pkg::S_DIV2;
            pwlti_pkg::S_DIV2:   if (!dbusy) state_next = pwlti_pkg::S_DIV3;
            pwlti_pkg::S_DIV3:   if (!dbusy) state_next = pwlti_pkg::S_DONE;
            pwlti_pkg::S_DONE:   state_next = pwlti_pkg::S_IDLE;
            default:             state_next = pwlti_pkg::S_IDLE;
        endcase
        // decisions taken in the datapath override the plain sequence
        if (state_reg == pwlti_pkg::S_CLASS && go_mod)    state_next = pwlti_pkg::S_MODDIV;
        if (state_reg == pwlti_pkg::S_CLASS && go_scan)   state_next = pwlti_pkg::S_SCAN;
        if (state_reg == pwlti_pkg::S_SCANW && scan_end)  state_next = scan_flat
                                                          ? pwlti_pkg::S_DONE
                                                          : pwlti_pkg::S_FETCH;
    end

    assign last  = AW'(n_reg - 1'b1);
    assign below = (W+2)'(c_reg.key_x) < (W+2)'(x0_reg);
    assign above = !below && ((W+2)'(c_reg.key_x) >= (W+2)'(xn_reg));
    assign go_mod  = (n_reg != NW'(1)) && (below || above)
                   && (mode == pwlti_pkg::MODE_REPEAT) && (span > 0);
    assign go_scan = (n_reg != NW'(1)) && !(below || above);
    // scan: xrd_reg holds x[i]
    assign scan_end  = (q_reg < (W+2)'(xrd_reg)) || (i_reg == last);
    assign scan_flat = !(q_reg < (W+2)'(xrd_reg));

    // |y_hi - y_lo| while the upper entry sits in the read registers
    assign ady_now = ((W+2)'(yrd_reg) < (W+2)'(ylo_reg))
                   ? DEN_W'((W+2)'(ylo_reg) - (W+2)'(yrd_reg))
                   : DEN_W'((W+2)'(yrd_reg) - (W+2)'(ylo_reg));

    // divider start and operands
    always_comb
    begin
        dstart = 1'b0;
        dnum   = '0;
        dden   = dx_reg;
        case (state_reg)
            pwlti_pkg::S_CLASS:
            begin
                dstart = go_mod;
                dnum   = NUM_W'(rel[W+1] ? -rel : rel);
                dden   = DEN_W'(span);
            end
            pwlti_pkg::S_FETCHW:
            begin
                // slope magnitude
                dstart = 1'b1;
                dnum   = NUM_W'(ady_now) << FRAC_BITS;
                dden   = DEN_W'((W+2)'(xrd_reg) - (W+2)'(xlo_reg));
            end
            pwlti_pkg::S_DIV1:
            begin
                // ady * (t >> 16)
                dstart = !dbusy;
                dnum   = NUM_W'(ady_reg) * NUM_W'(t_reg >> 16);
            end
            pwlti_pkg::S_DIV2:
            begin
                dstart = !dbusy;
                dnum   = (NUM_W'(drem) << 16) + NUM_W'(ady_reg) * NUM_W'(t_reg[15:0]);
            end
            default:
            begin
                dstart = 1'b0;
            end
        endcase
    end

    // memory read address
    always_comb
    begin
        case (state_reg)
            pwlti_pkg::S_IDLE:  raddr = '0;
            pwlti_pkg::S_READ0: raddr = last;
            pwlti_pkg::S_FETCH: raddr = i_reg;
            default:            raddr = i_reg;
        endcase
    end

    // table memory
    always_ff @(posedge clk)
    begin
        if (state_reg == pwlti_pkg::S_LOAD
            && {{(32-pwlti_pkg::IDX_W){1'b0}}, c_reg.entry_index} < 32'(TABLE_DEPTH))
        begin
            xmem[AW'(c_reg.entry_index)] <= c_reg.key_x;
            ymem[AW'(c_reg.entry_index)] <= c_reg.entry_y;
        end
        xrd_reg <= xmem[(state_reg == pwlti_pkg::S_LOAD)
                        ? AW'(c_reg.entry_index - 1'b1) : raddr];
        yrd_reg <= ymem[raddr];
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pwlti_pkg::S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == pwlti_pkg::S_DONE)
                rv_reg <= 1'b1;
            else if (res_ready)
                rv_reg <= 1'b0;
        end
    end

    assign cmd_pop = (state_reg == pwlti_pkg::S_IDLE) && cmd_valid && !rv_reg;

    function automatic logic signed [W-1:0] sat(input logic signed [W+3:0] v);
        logic signed [W+3:0] mx, mn;
        mx = (W+4)'({1'b0, {(W-1){1'b1}}});
        mn = -mx - 1;
        if (v > mx)      sat = W'(mx);
        else if (v < mn) sat = W'(mn);
        else             sat = W'(v);
    endfunction

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            pwlti_pkg::S_IDLE:
            begin
                c_reg <= cmd;
                n_reg <= nclip;
                i_reg <= '0;
            end
            pwlti_pkg::S_LOADW:
            begin
                res_reg.interp_value <= '0;
                res_reg.slope        <= '0;
                res_reg.status       <= (c_reg.entry_index != '0
                    && {{(32-pwlti_pkg::IDX_W){1'b0}}, c_reg.entry_index} < 32'(TABLE_DEPTH)
                    && c_reg.key_x <= xrd_reg) ? pwlti_pkg::ST_ORDER : pwlti_pkg::ST_OK;
            end
            pwlti_pkg::S_READ0:
            begin
                x0_reg <= xrd_reg;
                y0_reg <= yrd_reg;
            end
            pwlti_pkg::S_READN:
            begin
                xn_reg <= xrd_reg;
                yn_reg <= yrd_reg;
            end
            pwlti_pkg::S_CLASS:
            begin
                q_reg <= (W+2)'(c_reg.key_x);
                res_reg.slope <= '0;
                res_reg.status <= pwlti_pkg::ST_OK;
                res_reg.interp_value <= below ? y0_reg : yn_reg;
                if (n_reg == NW'(1))
                    res_reg.interp_value <= y0_reg;
                else if (below || above)
                begin
                    if (mode == pwlti_pkg::MODE_ERROR)
                    begin
                        res_reg.interp_value <= '0;
                        res_reg.status <= pwlti_pkg::ST_ERROR;
                    end
                    else if (mode == pwlti_pkg::MODE_WARN)
                        res_reg.status <= pwlti_pkg::ST_WARN;
                end
                neg_reg <= rel[W+1];
            end
            pwlti_pkg::S_MODDIV:
                if (!dbusy)
                    q_reg <= (W+2)'(x0_reg) + ((neg_reg && drem != '0)
                             ? (W+2)'(span) - (W+2)'(drem) : (W+2)'(drem));
            pwlti_pkg::S_SCANW:
            begin
                if (!(q_reg < (W+2)'(xrd_reg)))
                begin
                    xlo_reg <= xrd_reg;
                    ylo_reg <= yrd_reg;
                    res_reg.interp_value <= yrd_reg;
                    res_reg.slope <= '0;
                    if (i_reg != last) i_reg <= i_reg + 1'b1;
                end
            end
            pwlti_pkg::S_FETCHW:
            begin
                ady_reg <= ady_now;
                neg_reg <= yrd_reg < ylo_reg;
                t_reg   <= DEN_W'(q_reg - (W+2)'(xlo_reg));
                dx_reg  <= DEN_W'((W+2)'(xrd_reg) - (W+2)'(xlo_reg));
            end
            pwlti_pkg::S_DIV1:
                if (!dbusy) sm_reg <= (DEN_W+FRAC_BITS)'(dquot);
            pwlti_pkg::S_DIV2:
                if (!dbusy) hiq_reg <= dquot << 16;
            pwlti_pkg::S_DIV3:
                if (!dbusy)
                begin
                    res_reg.interp_value <= sat(neg_reg
                        ? (W+4)'(ylo_reg) - (W+4)'(hiq_reg + dquot)
                        : (W+4)'(ylo_reg) + (W+4)'(hiq_reg + dquot));
                    res_reg.slope <= neg_reg
                        ? ((sm_reg > (DEN_W+FRAC_BITS)'(32'h8000_0000))
                           ? 32'sh8000_0000 : W'(-(W+1)'(sm_reg)))
                        : ((sm_reg > (DEN_W+FRAC_BITS)'(32'h7FFF_FFFF))
                           ? 32'sh7FFF_FFFF : W'(sm_reg));
                    res_reg.status <= pwlti_pkg::ST_OK;
                end
            default:
            begin
                c_reg <= c_reg;
            end
        endcase
    end
endmodule

>>> hdl/pwlti_front.sv
// front end: accepts input words and configuration, feeds the queue
// depends on pwlti_pkg, pwlti_io_pkg, pwlti_if
module pwlti_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    pwlti_if.sink                         in_ch,
    input  logic                          cfg_we,
    input  logic [0:0]                    cfg_index,
    input  logic [pwlti_pkg::CNT_W-1:0]   cfg_data,
    input  logic                          q_full,
    output logic                          q_push,
    output pwlti_pkg::cmd_t               q_data,
    output logic [pwlti_pkg::MODE_W-1:0]  mode,
    output logic [pwlti_pkg::CNT_W-1:0]   entries
);
    logic [pwlti_pkg::MODE_W-1:0] mode_reg;
    logic [pwlti_pkg::CNT_W-1:0]  entries_reg;

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;
    assign q_data      = '{action: in_ch.data.action, entry_index: in_ch.data.entry_index,
                           entry_y: in_ch.data.entry_y, key_x: in_ch.data.key_x};
    assign mode        = mode_reg;
    assign entries     = entries_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= pwlti_pkg::MODE_WARN;
            entries_reg <= pwlti_pkg::CNT_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pwlti_pkg::REG_BOUNDS:  mode_reg    <= cfg_data[pwlti_pkg::MODE_W-1:0];
                pwlti_pkg::REG_ENTRIES: entries_reg <= cfg_data;
                default:                mode_reg    <= mode_reg;
            endcase
        end
    end
endmodule

>>> hdl/piecewise_linear_table_interp.sv
// piecewise-linear interpolation table, top level
// rate set by the segment scan (states SCAN and SCANW per entry) and up to four 68-step divisions
// one item in the back end at a time; two-word queue decouples input
// reset: asynchronous active low, bounds_mode warn, entries_in_use 1
module piecewise_linear_table_interp #(
    parameter int TABLE_DEPTH = pwlti_pkg::TABLE_DEPTH_DEF,
    parameter int FRAC_BITS   = pwlti_pkg::FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    pwlti_if.sink                       in_ch,
    pwlti_if.source                     out_ch,
    input  logic                        cfg_we,
    input  logic [0:0]                  cfg_index,
    input  logic [pwlti_pkg::CNT_W-1:0] cfg_data
);
    logic q_full, q_push, q_empty, q_pop;
    pwlti_pkg::cmd_t q_in, q_out;
    logic [pwlti_pkg::MODE_W-1:0] mode;
    logic [pwlti_pkg::CNT_W-1:0]  entries;

    pwlti_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .cfg_we(cfg_we),
        .cfg_index(cfg_index), .cfg_data(cfg_data), .q_full(q_full),
        .q_push(q_push), .q_data(q_in), .mode(mode), .entries(entries)
    );

    pwlti_fifo u_fifo (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .empty(q_empty)
    );

    pwlti_back #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(!q_empty), .cmd(q_out), .cmd_pop(q_pop),
        .mode(mode), .entries(entries), .res_valid(out_ch.valid),
        .res_ready(out_ch.ready), .res(out_ch.data)
    );
endmodule

>>> hdl/pwlti_checker.sv
// port-level checker for the interpolation table, bound to the top level
// depends on pwlti_pkg
module pwlti_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [pwlti_pkg::STAT_W-1:0] out_status,
    input logic [31:0]                 out_slope
);
    // result valid and status held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_status))
        else $error("result dropped while stalled");

    // results with warn or error status carry no slope
    a_edge: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status == pwlti_pkg::ST_WARN
                   || out_status == pwlti_pkg::ST_ERROR) |-> out_slope == '0)
        else $error("slope on out-of-range result");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
        else $error("result after reset");

    // an offered input word stays offered until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input word withdrawn before accept");
endmodule

bind piecewise_linear_table_interp pwlti_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.data.status), .out_slope(out_ch.data.slope)
);
